>>> rtl/dsc_pkg.sv
`default_nettype none

package dsc_pkg;

  localparam int unsigned FEAT_W = 16;
  localparam int unsigned CFG_W  = 64;
  localparam int unsigned BIAS_W = 48;
  localparam int unsigned PROB_W = 16;
  localparam int unsigned CLASS_W = 2;
  localparam int unsigned NUM_FEAT = 4;
  localparam int unsigned NUM_CLASS = 3;

  localparam logic [63:0] ONE_Q31      = 64'h0000_0000_8000_0000;
  localparam logic [63:0] EXP_STEP_Q31 = 64'd2139111403;  // exp(-1/256) in Q1.31

  typedef logic [PROB_W-1:0]  prob_t;
  typedef logic [CLASS_W-1:0] class_t;

  typedef enum logic [1:0] {
    REG_WCOL0 = 2'd0,
    REG_WCOL1 = 2'd1,
    REG_WCOL2 = 2'd2,
    REG_BIAS  = 2'd3
  } cfg_reg_t;

  localparam class_t CLASS_ZERO = 2'd0;
  localparam class_t CLASS_ONE  = 2'd1;
  localparam class_t CLASS_TWO  = 2'd2;

  // Q1.31 product, rounded half up.
  function automatic logic [63:0] mul_q31(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b + 64'h0000_0000_4000_0000;
    return p >> 31;
  endfunction

  // Sigmoid value at the lower edge of table bin k, for a table of 2^tbits
  // bins spanning -8 to +8. Evaluated only while the design elaborates; the
  // quotient is formed by shift and subtract.
  function automatic prob_t sig_entry(input int unsigned k, input int unsigned tbits);
    longint      xu;
    logic [63:0] m;
    logic [63:0] e;
    logic [63:0] pw;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] dvd;
    logic [63:0] rem;
    logic [63:0] quo;
    xu = (longint'(k) << (12 - tbits)) - 64'sd2048;
    m = (xu < 0) ? 64'(-xu) : 64'(xu);
    e = ONE_Q31;
    pw = EXP_STEP_Q31;
    for (int b = 0; b < 12; b++) begin
      if (m[b]) begin
        e = mul_q31(e, pw);
      end
      pw = mul_q31(pw, pw);
    end
    num = (xu >= 0) ? ONE_Q31 : e;
    den = ONE_Q31 + e;
    dvd = (num << 16) + (den >> 1);
    rem = '0;
    quo = '0;
    for (int i = 47; i >= 0; i--) begin
      rem = {rem[62:0], dvd[i]};
      if (rem >= den) begin
        rem = rem - den;
        quo[i] = 1'b1;
      end
    end
    if (quo > 64'd65535) begin
      return '1;
    end
    return quo[PROB_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/dense_sigmoid_classifier.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    feature_zero .. feature_three
// out       output     out_valid / out_ready  prob_zero, prob_one, prob_two, best_class
// cfg       input      cfg_write              cfg_index, cfg_data
//
// The block takes one feature vector per cycle while the pipeline can move. Its
// registered stages: multiply, add, round and saturate, sigmoid table, best-class pick.
// Every stage has its own valid bit, and a stage loads whenever it is empty or the
// stage after it moves, so bubbles close up while the output is held.
// Reset is synchronous and clears the valid bits and the weight and bias registers.
// A result that is not taken stays on the output unchanged until out_ready is high.
`default_nettype none

module dense_sigmoid_classifier import dsc_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int SIGMOID_TABLE_BITS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [FEAT_W-1:0] feature_zero,
  input  wire logic [FEAT_W-1:0] feature_one,
  input  wire logic [FEAT_W-1:0] feature_two,
  input  wire logic [FEAT_W-1:0] feature_three,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output prob_t                  prob_zero,
  output prob_t                  prob_one,
  output prob_t                  prob_two,
  output class_t                 best_class,
  input  wire logic              cfg_write,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  localparam int L      = DATA_WIDTH;
  localparam int HALF   = DATA_WIDTH / 2;
  localparam int PROD_W = 2 * DATA_WIDTH;
  // Four products and a shifted bias never need more than three extra bits.
  localparam int SUM_W  = 2 * DATA_WIDTH + 3;
  localparam int NSTAGE = 5;
  localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) << (HALF - 1);

  // Weight and bias registers.
  logic [CFG_W-1:0]  wcol0;
  logic [CFG_W-1:0]  wcol1;
  logic [CFG_W-1:0]  wcol2;
  logic [BIAS_W-1:0] bias_pack;

  always_ff @(posedge clk) begin
    if (rst) begin
      wcol0     <= '0;
      wcol1     <= '0;
      wcol2     <= '0;
      bias_pack <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WCOL0: wcol0 <= cfg_data;
        REG_WCOL1: wcol1 <= cfg_data;
        REG_WCOL2: wcol2 <= cfg_data;
        REG_BIAS:  bias_pack <= cfg_data[BIAS_W-1:0];
      endcase
    end
  end

  // Stage flow control. A stage loads when it is empty or its successor loads.
  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] load;

  always_comb begin
    load[NSTAGE-1] = !vld[NSTAGE-1] || out_ready;
    for (int s = NSTAGE - 2; s >= 0; s--) begin
      load[s] = !vld[s] || load[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) begin
        vld[0] <= in_valid;
      end
      for (int s = 1; s < NSTAGE; s++) begin
        if (load[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  assign in_ready  = load[0];
  assign out_valid = vld[NSTAGE-1];

  // Stage one: twelve signed products, taken straight from the input ports.
  logic signed [L-1:0]      feat [NUM_FEAT];
  logic [CFG_W-1:0]         wcol [NUM_CLASS];
  logic signed [PROD_W-1:0] prod [NUM_CLASS][NUM_FEAT];

  assign feat[0] = feature_zero[L-1:0];
  assign feat[1] = feature_one[L-1:0];
  assign feat[2] = feature_two[L-1:0];
  assign feat[3] = feature_three[L-1:0];
  assign wcol[0] = wcol0;
  assign wcol[1] = wcol1;
  assign wcol[2] = wcol2;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      for (int c = 0; c < NUM_CLASS; c++) begin
        for (int i = 0; i < NUM_FEAT; i++) begin
          prod[c][i] <= feat[i] * $signed(wcol[c][i*L +: L]);
        end
      end
    end
  end

  // Stage two: exact sum of the products and the bias, aligned to the
  // product's fraction point.
  logic signed [L-1:0]     bias [NUM_CLASS];
  logic signed [SUM_W-1:0] acc  [NUM_CLASS];

  for (genvar c = 0; c < NUM_CLASS; c++) begin : g_bias
    assign bias[c] = bias_pack[c*L +: L];
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      for (int c = 0; c < NUM_CLASS; c++) begin
        acc[c] <= SUM_W'(prod[c][0]) + SUM_W'(prod[c][1]) + SUM_W'(prod[c][2])
                  + SUM_W'(prod[c][3]) + (SUM_W'(bias[c]) <<< HALF);
      end
    end
  end

  // Stage three: round to the weight format and clamp to the lane range.
  logic signed [SUM_W-1:0] rnd [NUM_CLASS];
  logic signed [L-1:0]     sat [NUM_CLASS];

  always_comb begin
    for (int c = 0; c < NUM_CLASS; c++) begin
      rnd[c] = (acc[c] + RND) >>> HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (load[2]) begin
      for (int c = 0; c < NUM_CLASS; c++) begin
        if ((&rnd[c][SUM_W-1:L-1]) || !(|rnd[c][SUM_W-1:L-1])) begin
          sat[c] <= rnd[c][L-1:0];
        end else if (rnd[c][SUM_W-1]) begin
          sat[c] <= {1'b1, {(L-1){1'b0}}};
        end else begin
          sat[c] <= {1'b0, {(L-1){1'b1}}};
        end
      end
    end
  end

  // Stage four: one sigmoid table per class.
  prob_t sig [NUM_CLASS];

  for (genvar c = 0; c < NUM_CLASS; c++) begin : g_sig
    dsc_sigmoid #(
      .DATA_WIDTH         (DATA_WIDTH),
      .SIGMOID_TABLE_BITS (SIGMOID_TABLE_BITS)
    ) u_sig (
      .clk  (clk),
      .en   (load[3]),
      .sum  (sat[c]),
      .prob (sig[c])
    );
  end

  // Stage five: output register and the best class. A later class wins
  // only when strictly larger, so ties go to the lower index.
  prob_t  best_val;
  class_t best_idx;

  always_comb begin
    best_idx = CLASS_ZERO;
    best_val = sig[0];
    if (sig[1] > best_val) begin
      best_idx = CLASS_ONE;
      best_val = sig[1];
    end
    if (sig[2] > best_val) begin
      best_idx = CLASS_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (load[4]) begin
      prob_zero  <= sig[0];
      prob_one   <= sig[1];
      prob_two   <= sig[2];
      best_class <= best_idx;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dsc_sigmoid.sv
`default_nettype none

module dsc_sigmoid import dsc_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int SIGMOID_TABLE_BITS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic signed [DATA_WIDTH-1:0] sum,
  output prob_t                             prob
);

  localparam int TAB_N = 2 ** SIGMOID_TABLE_BITS;

  logic [DATA_WIDTH-1:0]         u;
  logic [SIGMOID_TABLE_BITS-1:0] k;
  prob_t                         tab [TAB_N];

  for (genvar g = 0; g < TAB_N; g++) begin : g_tab
    localparam prob_t ENTRY = sig_entry(g, SIGMOID_TABLE_BITS);
    assign tab[g] = ENTRY;
  end

  // Offset binary: adding half the range flips the sign bit.
  assign u = {~sum[DATA_WIDTH-1], sum[DATA_WIDTH-2:0]};

  if (DATA_WIDTH >= SIGMOID_TABLE_BITS) begin : g_idx_top
    assign k = u[DATA_WIDTH-1 -: SIGMOID_TABLE_BITS];
  end else begin : g_idx_pad
    assign k = {u, {(SIGMOID_TABLE_BITS - DATA_WIDTH){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prob <= tab[k];
    end
  end

endmodule

`default_nettype wire

>>> rtl/dsc_checker.sv
`default_nettype none

module dsc_checker import dsc_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire prob_t             prob_zero,
  input wire prob_t             prob_one,
  input wire prob_t             prob_two,
  input wire class_t            best_class
);

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // A held result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(prob_zero) && $stable(prob_one)
      && $stable(prob_two) && $stable(best_class))
    else $error("result payload changed while stalled");

  // The best class is the lowest index holding the largest probability.
  a_best: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (best_class == CLASS_ZERO && prob_zero >= prob_one && prob_zero >= prob_two)
      || (best_class == CLASS_ONE && prob_one > prob_zero && prob_one >= prob_two)
      || (best_class == CLASS_TWO && prob_two > prob_zero && prob_two > prob_one))
    else $error("best_class does not point at the lowest-index maximum");

  // With the output stage empty the pipeline can always move, so input is taken.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the output stage is empty");

endmodule

bind dense_sigmoid_classifier dsc_checker u_dsc_checker (.*);

`default_nettype wire
